[hw/rtl/grid_line_of_sight_defines.svh]
// Assertion macros shared by the line-of-sight block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLOS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid_line_of_sight: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid_line_of_sight: next-cycle check failed");

`endif

[hw/rtl/glos_pkg.sv]
package glos_pkg;

	// Map size and derived widths.
	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int MAP_DEPTH   = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W      = $clog2(MAP_DEPTH);

	// Coordinates are fixed at six bits by the item format.
	localparam int COORD_W = 6;
	// Crossing times reach (1 + 2 * 63) * 63, which fits in 2 * COORD_W + 1 bits.
	localparam int TIME_W  = 2 * COORD_W + 1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [TIME_W-1:0]  xtime_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// Which cell the datapath reads.
	typedef logic [2:0] rd_sel_t;
	localparam rd_sel_t SEL_START  = 3'd0;
	localparam rd_sel_t SEL_GOAL   = 3'd1;
	localparam rd_sel_t SEL_STEP_X = 3'd2;
	localparam rd_sel_t SEL_STEP_Y = 3'd3;
	localparam rd_sel_t SEL_DIAG   = 3'd4;

	typedef struct packed {
		logic    clr;     // write zero at the sweep counter
		logic    wr;      // store one map cell from the input word
		logic    load;    // latch a query
		logic    rd_en;   // read one cell and check it next cycle
		rd_sel_t rd_sel;
		logic    adv_x;
		logic    adv_y;
		logic    finish;  // present the result
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic more;
		logic tie;
		logic x_first;
	} status_t;

	function automatic logic in_grid(coord_t x, coord_t y);
		return (int'(x) < GRID_WIDTH) && (int'(y) < GRID_HEIGHT);
	endfunction

	function automatic addr_t cell_addr(coord_t x, coord_t y);
		return ADDR_W'(int'(y) * GRID_WIDTH + int'(x));
	endfunction

endpackage

[hw/rtl/glos_ctrl.sv]
module glos_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	input  glos_pkg::status_t status,
	output glos_pkg::cmd_t   cmd,
	output logic             busy
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RD_S   = 3'd2;
	localparam logic [2:0] ST_RD_G   = 3'd3;
	localparam logic [2:0] ST_WALK   = 3'd4;
	localparam logic [2:0] ST_SIDE_Y = 3'd5;
	localparam logic [2:0] ST_DIAG   = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = glos_pkg::SEL_START;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req_type) begin
						cmd.load = 1'b1;
						state_d  = ST_RD_S;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_RD_S: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = glos_pkg::SEL_START;
				state_d    = ST_RD_G;
			end
			ST_RD_G: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = glos_pkg::SEL_GOAL;
				state_d    = ST_WALK;
			end
			ST_WALK: begin
				priority if (!status.more) begin
					state_d = ST_FINISH;
				end else if (status.tie) begin
					// First side cell of a diagonal step.
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = glos_pkg::SEL_STEP_X;
					state_d    = ST_SIDE_Y;
				end else if (status.x_first) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = glos_pkg::SEL_STEP_X;
					cmd.adv_x  = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = glos_pkg::SEL_STEP_Y;
					cmd.adv_y  = 1'b1;
				end
			end
			ST_SIDE_Y: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = glos_pkg::SEL_STEP_Y;
				state_d    = ST_DIAG;
			end
			ST_DIAG: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = glos_pkg::SEL_DIAG;
				cmd.adv_x  = 1'b1;
				cmd.adv_y  = 1'b1;
				state_d    = ST_WALK;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/glos_dp.sv]
module glos_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  glos_pkg::cmd_t    cmd,
	input  glos_pkg::coord_t  cell_x,
	input  glos_pkg::coord_t  cell_y,
	input  logic              hard_block,
	input  logic              soft_block,
	input  glos_pkg::coord_t  start_x,
	input  glos_pkg::coord_t  start_y,
	input  glos_pkg::coord_t  goal_x,
	input  glos_pkg::coord_t  goal_y,
	input  logic              allow_endpoints,
	output glos_pkg::status_t status,
	output logic              done,
	output logic              clear_sight
);

	// Sight map: bit 0 hard, bit 1 soft.
	logic [1:0] map_mem [glos_pkg::MAP_DEPTH];

	glos_pkg::addr_t  clr_cnt_q;
	glos_pkg::coord_t ax_q, ay_q, bx_q, by_q;
	logic             allow_q;
	glos_pkg::coord_t cx_q, cy_q, ix_q, iy_q, nx_q, ny_q;
	logic             sx_neg_q, sy_neg_q;
	glos_pkg::xtime_t tx_q, ty_q;

	glos_pkg::coord_t step_x, step_y, rd_x, rd_y;

	logic [1:0]       rd_data_s1;
	glos_pkg::coord_t chk_x_s1, chk_y_s1;
	logic             chk_valid_s1;
	logic             is_end;
	logic             blk_now;
	logic             blk_q;
	logic             done_q;
	logic             clear_sight_q;

	assign step_x = sx_neg_q ? cx_q - 1'b1 : cx_q + 1'b1;
	assign step_y = sy_neg_q ? cy_q - 1'b1 : cy_q + 1'b1;

	always_comb begin
		unique case (cmd.rd_sel)
			glos_pkg::SEL_START: begin
				rd_x = ax_q;
				rd_y = ay_q;
			end
			glos_pkg::SEL_GOAL: begin
				rd_x = bx_q;
				rd_y = by_q;
			end
			glos_pkg::SEL_STEP_X: begin
				rd_x = step_x;
				rd_y = cy_q;
			end
			glos_pkg::SEL_STEP_Y: begin
				rd_x = cx_q;
				rd_y = step_y;
			end
			glos_pkg::SEL_DIAG: begin
				rd_x = step_x;
				rd_y = step_y;
			end
			default: begin
				rd_x = ax_q;
				rd_y = ay_q;
			end
		endcase
	end

	// Write port: the sweep after reset, or one cell from a write word.
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			map_mem[clr_cnt_q] <= 2'b00;
		end else if (cmd.wr && glos_pkg::in_grid(cell_x, cell_y)) begin
			map_mem[glos_pkg::cell_addr(cell_x, cell_y)] <= {soft_block, hard_block};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= map_mem[glos_pkg::cell_addr(rd_x, rd_y)];
			chk_x_s1   <= rd_x;
			chk_y_s1   <= rd_y;
		end
	end

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q     <= start_x;
			ay_q     <= start_y;
			bx_q     <= goal_x;
			by_q     <= goal_y;
			allow_q  <= allow_endpoints;
			cx_q     <= start_x;
			cy_q     <= start_y;
			ix_q     <= '0;
			iy_q     <= '0;
			nx_q     <= (goal_x > start_x) ? goal_x - start_x : start_x - goal_x;
			ny_q     <= (goal_y > start_y) ? goal_y - start_y : start_y - goal_y;
			sx_neg_q <= (goal_x < start_x);
			sy_neg_q <= (goal_y < start_y);
			tx_q     <= glos_pkg::TIME_W'((goal_y > start_y) ? goal_y - start_y
				: start_y - goal_y);
			ty_q     <= glos_pkg::TIME_W'((goal_x > start_x) ? goal_x - start_x
				: start_x - goal_x);
		end else begin
			if (cmd.adv_x) begin
				cx_q <= step_x;
				ix_q <= ix_q + 1'b1;
				tx_q <= tx_q + glos_pkg::TIME_W'({ny_q, 1'b0});
			end
			if (cmd.adv_y) begin
				cy_q <= step_y;
				iy_q <= iy_q + 1'b1;
				ty_q <= ty_q + glos_pkg::TIME_W'({nx_q, 1'b0});
			end
		end
	end

	assign status.more     = (ix_q < nx_q) || (iy_q < ny_q);
	assign status.tie      = (tx_q == ty_q);
	assign status.x_first  = (tx_q < ty_q);
	assign status.clr_last = (clr_cnt_q == glos_pkg::ADDR_W'(glos_pkg::MAP_DEPTH - 1));

	// A cell blocks when off the map, hard, or soft and not an exempt endpoint.
	assign is_end  = ((chk_x_s1 == ax_q) && (chk_y_s1 == ay_q)) ||
		((chk_x_s1 == bx_q) && (chk_y_s1 == by_q));
	assign blk_now = chk_valid_s1 && (!glos_pkg::in_grid(chk_x_s1, chk_y_s1) ||
		rd_data_s1[0] || (rd_data_s1[1] && !(allow_q && is_end)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q     <= '0;
			chk_valid_s1  <= 1'b0;
			blk_q         <= 1'b0;
			done_q        <= 1'b0;
			clear_sight_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			chk_valid_s1 <= cmd.rd_en;
			if (cmd.load) begin
				blk_q <= 1'b0;
			end else if (blk_now) begin
				blk_q <= 1'b1;
			end
			done_q <= cmd.finish;
			if (cmd.finish) begin
				clear_sight_q <= !blk_q;
			end
		end
	end

	assign done        = done_q;
	assign clear_sight = clear_sight_q;

endmodule

[hw/rtl/grid_line_of_sight.sv]
// Line-of-sight engine over a 64 by 64 sight map. A word is taken at a clock edge where start
// is high and busy is low. A write word (req_type 0) stores the hard and soft bits of one cell
// in that same edge and gives no result; busy stays low, so writes can follow every cycle. A
// query word (req_type 1) walks the supercover line from the start cell to the goal cell, one
// map read per cycle from the sight memory, with busy held high; at each exact diagonal
// crossing it also reads the two side cells. The corner-to-corner diagonal, which crosses a
// corner at every step, keeps busy high the longest. The answer appears on clear_sight, marked
// by done high for exactly one cycle, in the first cycle with busy low after the walk;
// clear_sight then holds it until the next query's result.
// The receiver cannot stall: done is not held, so the word must be captured in that cycle.
// After reset the map is cleared to open by a sweep over all 4096 cells, one cell per cycle, with
// busy held high; no word is taken until it ends.
`include "grid_line_of_sight_defines.svh"

module grid_line_of_sight (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [5:0] cell_x,
	input  logic [5:0] cell_y,
	input  logic hard_block,
	input  logic soft_block,
	input  logic [5:0] start_x,
	input  logic [5:0] start_y,
	input  logic [5:0] goal_x,
	input  logic [5:0] goal_y,
	input  logic allow_endpoints,
	output logic done,
	output logic clear_sight
);

	glos_pkg::cmd_t    cmd;
	glos_pkg::status_t status;

	// The controller sequences the sweep, the writes and the query walk.
	glos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the map, the walk position, the crossing times and the result.
	glos_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cell_x          (cell_x),
		.cell_y          (cell_y),
		.hard_block      (hard_block),
		.soft_block      (soft_block),
		.start_x         (start_x),
		.start_y         (start_y),
		.goal_x          (goal_x),
		.goal_y          (goal_y),
		.allow_endpoints (allow_endpoints),
		.status          (status),
		.done            (done),
		.clear_sight     (clear_sight)
	);

	// A result is only shown once the walk has ended and the block is free again.
	`GLOS_ASSERT_SAME(a_done_idle, done, !busy)
	// A taken query always occupies the block in the next cycle.
	`GLOS_ASSERT_NEXT(a_query_busy, start && !busy && req_type, busy)
	// A taken write produces no result and leaves the block free.
	`GLOS_ASSERT_NEXT(a_write_silent, start && !busy && !req_type, !done && !busy)

endmodule
